/* hw/rtl/tolerant_vertex_dedup_table_assert.svh */
// Assertion macros for the tolerant vertex dedup table.
// Included by the top-level RTL file, which carries the concurrent assertions; no dependencies.
`ifndef TOLERANT_VERTEX_DEDUP_TABLE_ASSERT_SVH
`define TOLERANT_VERTEX_DEDUP_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted
`define TVDT_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled while reset is asserted
`define TVDT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define TVDT_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define TVDT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* hw/rtl/tvdt_pkg.sv */
// Package for the tolerant vertex dedup table: sizes, types, codes and
// the coordinate helpers shared by the RTL files. No dependencies.
package tvdt_pkg;

  // Table geometry and coordinate width
  localparam int TABLE_DEPTH = 256;
  localparam int COORD_BITS  = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Fixed widths of the request and response fields
  localparam int FIELD_W   = 32;
  localparam int TOL_W     = 31;
  localparam int RIDX_W    = 8;
  localparam int VIDX_W    = 8;
  localparam int CNT_OUT_W = 9;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;

  // Difference and compare widths
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int CMP_W  = ((DIFF_W > TOL_W) ? DIFF_W : TOL_W) + 1;

  // About 0.01 in Q16.16
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(655);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [FIELD_W-1:0]    field_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } tvdt_point_t;

  localparam int POINT_W = $bits(tvdt_point_t);

  typedef enum logic [CMD_W-1:0] {
    CMD_MAP   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } tvdt_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_UNUSED = 2'd2
  } tvdt_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_FINISH
  } tvdt_state_e;

  // Scan read in flight: one memory read issued last cycle
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } tvdt_scan_t;

  // Compare stage result for one stored entry
  typedef struct packed {
    logic             vld;
    logic             hit;
    logic [IDX_W-1:0] idx;
    tvdt_point_t      pt;
  } tvdt_hit_t;

  // One response item
  typedef struct packed {
    logic [VIDX_W-1:0]    vertex_index;
    logic                 matched;
    logic [STATUS_W-1:0]  status;
    field_t               x;
    field_t               y;
    field_t               z;
    logic [CNT_OUT_W-1:0] entry_count;
  } tvdt_result_t;

  // Sign-extend or wrap a request coordinate to the stored width
  function automatic coord_t to_coord(field_t v);
    return COORD_BITS'(v);
  endfunction

  // Sign-extend or wrap a stored coordinate to the response width
  function automatic field_t to_field(coord_t c);
    return FIELD_W'(c);
  endfunction

  // |d| < tol, written as -tol < d < tol
  function automatic logic axis_close(diff_t d, logic [TOL_W-1:0] tol);
    logic signed [CMP_W-1:0] dd;
    logic signed [CMP_W-1:0] tt;
    dd = CMP_W'(d);
    tt = $signed(CMP_W'(tol));
    return (dd < tt) && (dd > -tt);
  endfunction

endpackage

/* hw/rtl/tvdt_req_if.sv */
// Request channel of the tolerant vertex dedup table: valid/ready plus the
// command payload. Depends on tvdt_pkg.
interface tvdt_req_if;
  import tvdt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  field_t            vertex_x;
  field_t            vertex_y;
  field_t            vertex_z;
  logic [RIDX_W-1:0] read_index;

  modport source (
    output valid, cmd, vertex_x, vertex_y, vertex_z, read_index,
    input  ready
  );

  modport sink (
    input  valid, cmd, vertex_x, vertex_y, vertex_z, read_index,
    output ready
  );
endinterface

/* hw/rtl/tvdt_rsp_if.sv */
// Response channel of the tolerant vertex dedup table: valid/ready plus the
// result payload. Depends on tvdt_pkg.
interface tvdt_rsp_if;
  import tvdt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [VIDX_W-1:0]    vertex_index;
  logic                 matched;
  logic [STATUS_W-1:0]  status;
  field_t               stored_x;
  field_t               stored_y;
  field_t               stored_z;
  logic [CNT_OUT_W-1:0] entry_count;

  modport source (
    output valid, vertex_index, matched, status, stored_x, stored_y, stored_z,
           entry_count,
    input  ready
  );

  modport sink (
    input  valid, vertex_index, matched, status, stored_x, stored_y, stored_z,
           entry_count,
    output ready
  );
endinterface

/* hw/rtl/tvdt_point_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read
// port. No dependencies.
module tvdt_point_ram #(
  parameter  int WIDTH = 96,
  parameter  int DEPTH = 256,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* hw/rtl/tvdt_match_unit.sv */
// Two-stage tolerance compare for the table scan: register the per-axis
// differences of the entry just read, then test them against the tolerance.
// Depends on tvdt_pkg.
module tvdt_match_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tvdt_pkg::tvdt_scan_t        scan_i,
  input  logic                        flush_i,
  input  tvdt_pkg::tvdt_point_t       rdata_i,
  input  tvdt_pkg::tvdt_point_t       query_i,
  input  logic [tvdt_pkg::TOL_W-1:0]  tol_i,
  output tvdt_pkg::tvdt_hit_t         hit_o
);
  import tvdt_pkg::*;

  logic             s1_vld_q, s1_vld_d;
  logic [IDX_W-1:0] s1_idx_q;
  tvdt_point_t      s1_pt_q;
  diff_t            s1_dx_q, s1_dy_q, s1_dz_q;
  diff_t            dx_d, dy_d, dz_d;

  // Form exact differences one bit wider than the coordinates
  always_comb begin
    dx_d     = DIFF_W'(query_i.x) - DIFF_W'(rdata_i.x);
    dy_d     = DIFF_W'(query_i.y) - DIFF_W'(rdata_i.y);
    dz_d     = DIFF_W'(query_i.z) - DIFF_W'(rdata_i.z);
    s1_vld_d = scan_i.vld && !flush_i;
  end

  // Hold the stage valid; drop it on a flush
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
    end
  end

  // Register differences and the entry itself
  always_ff @(posedge clk_i) begin
    if (scan_i.vld) begin
      s1_idx_q <= scan_i.idx;
      s1_pt_q  <= rdata_i;
      s1_dx_q  <= dx_d;
      s1_dy_q  <= dy_d;
      s1_dz_q  <= dz_d;
    end
  end

  // Test all three axes against the tolerance
  always_comb begin
    hit_o.vld = s1_vld_q;
    hit_o.hit = s1_vld_q && axis_close(s1_dx_q, tol_i) && axis_close(s1_dy_q, tol_i)
                && axis_close(s1_dz_q, tol_i);
    hit_o.idx = s1_idx_q;
    hit_o.pt  = s1_pt_q;
  end

endmodule

/* hw/rtl/tolerant_vertex_dedup_table.sv */
// Tolerant vertex dedup table: top level with the command sequencer.
// Map: the scan reads one entry a cycle from the point memory in index order; the first
// match wins, else the point is appended unless the table is full. Clear, undefined
// command and unused-index read go straight to finish; a used-entry read passes ST_READ.
// One request at a time. Reset clears the entry count and the sequencer and sets the
// tolerance to 655; the point memory is not cleared and is only read below the entry count.
`include "tolerant_vertex_dedup_table_assert.svh"
module tolerant_vertex_dedup_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  tvdt_req_if.sink                   req_i,
  tvdt_rsp_if.source                 rsp_o,
  input  logic                       cfg_we_i,
  input  logic [tvdt_pkg::TOL_W-1:0] cfg_wdata_i
);
  import tvdt_pkg::*;

  tvdt_state_e      state_q, state_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic [CNT_W-1:0] addr_q, addr_d;
  logic [TOL_W-1:0] tol_q;
  tvdt_scan_t       scan_q, scan_d;
  tvdt_point_t      qry_q;
  tvdt_result_t     res_q, res_d;
  tvdt_result_t     out_q;
  logic             out_vld_q, out_vld_d;
  logic             out_load;
  logic             flush;
  logic             req_ready;
  logic             req_accept;
  logic             rd_in_range;
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  tvdt_point_t      ram_rdata;
  tvdt_hit_t        hit;

  // Point memory
  tvdt_point_ram #(
    .WIDTH (POINT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (qry_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Tolerance compare pipeline
  tvdt_match_unit u_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .scan_i  (scan_q),
    .flush_i (flush),
    .rdata_i (ram_rdata),
    .query_i (qry_q),
    .tol_i   (tol_q),
    .hit_o   (hit)
  );

  assign req_accept  = req_i.valid && req_ready;
  assign rd_in_range = (32'(req_i.read_index) < 32'(used_q))
                       && (32'(req_i.read_index) < TABLE_DEPTH);

  // Sequencer: next state, memory access and result
  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    addr_d    = addr_q;
    scan_d    = scan_q;
    scan_d.vld = 1'b0;
    res_d     = res_q;
    out_load  = 1'b0;
    flush     = 1'b0;
    req_ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = used_q[IDX_W-1:0];
    ram_re    = 1'b0;
    ram_raddr = addr_q[IDX_W-1:0];
    case (state_q)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_i.valid) begin
          res_d             = '0;
          res_d.entry_count = CNT_OUT_W'(used_q);
          case (req_i.cmd)
            CMD_MAP: begin
              addr_d  = '0;
              state_d = ST_SCAN;
            end
            CMD_CLEAR: begin
              used_d            = '0;
              res_d.entry_count = '0;
              state_d           = ST_FINISH;
            end
            CMD_READ: begin
              res_d.vertex_index = VIDX_W'(req_i.read_index);
              if (rd_in_range) begin
                ram_re    = 1'b1;
                ram_raddr = IDX_W'(req_i.read_index);
                state_d   = ST_READ;
              end else begin
                res_d.status = STATUS_UNUSED;
                state_d      = ST_FINISH;
              end
            end
            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (hit.hit) begin
          // First match in index order wins; drop reads still in flight
          flush              = 1'b1;
          res_d.vertex_index = VIDX_W'(hit.idx);
          res_d.matched      = 1'b1;
          res_d.x            = to_field(hit.pt.x);
          res_d.y            = to_field(hit.pt.y);
          res_d.z            = to_field(hit.pt.z);
          state_d            = ST_FINISH;
        end else if ((addr_q == used_q) && !scan_q.vld && !hit.vld) begin
          // No match: append unless the table is full
          if (used_q == CNT_W'(TABLE_DEPTH)) begin
            res_d.status = STATUS_FULL;
          end else begin
            ram_we             = 1'b1;
            res_d.vertex_index = VIDX_W'(used_q);
            used_d             = used_q + 1'b1;
            res_d.entry_count  = CNT_OUT_W'(used_d);
          end
          state_d = ST_FINISH;
        end else if (addr_q < used_q) begin
          // Issue the next entry read
          ram_re     = 1'b1;
          scan_d.vld = 1'b1;
          scan_d.idx = addr_q[IDX_W-1:0];
          addr_d     = addr_q + 1'b1;
        end
      end
      ST_READ: begin
        res_d.x = to_field(ram_rdata.x);
        res_d.y = to_field(ram_rdata.y);
        res_d.z = to_field(ram_rdata.z);
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register valid: set on load, clear when the response is taken
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      used_q    <= '0;
      addr_q    <= '0;
      scan_q    <= '0;
      out_vld_q <= 1'b0;
      tol_q     <= TOL_RESET;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      addr_q    <= addr_d;
      scan_q    <= scan_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers: query point, staged result, output result
  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      qry_q.x <= to_coord(req_i.vertex_x);
      qry_q.y <= to_coord(req_i.vertex_y);
      qry_q.z <= to_coord(req_i.vertex_z);
    end
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  // Drive the channels
  assign req_i.ready        = req_ready;
  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.vertex_index = out_q.vertex_index;
  assign rsp_o.matched      = out_q.matched;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.stored_x     = out_q.x;
  assign rsp_o.stored_y     = out_q.y;
  assign rsp_o.stored_z     = out_q.z;
  assign rsp_o.entry_count  = out_q.entry_count;

  // Assertions
  `TVDT_ASSERT_NEXT(a_append_counts, clk_i, rst_ni, ram_we,
                    used_q == $past(used_q) + 1'b1, "append did not advance the entry count")
  `TVDT_ASSERT_IMPL(a_hit_in_table, clk_i, rst_ni, hit.hit,
                    CNT_W'(hit.idx) < used_q, "match reported beyond the stored entries")
  `TVDT_ASSERT_IMPL(a_cmp_in_scan, clk_i, rst_ni, hit.vld,
                    state_q == ST_SCAN, "compare stage busy outside a scan")
  `TVDT_ASSERT_NEXT(a_finish_holds, clk_i, rst_ni,
                    (state_q == ST_FINISH) && out_vld_q && !rsp_o.ready,
                    state_q == ST_FINISH, "result left while output register was occupied")

endmodule

/* tb/sv/tb_tolerant_vertex_dedup_table.sv */
`timescale 1ns / 100ps
// Testbench for tolerant_vertex_dedup_table: a clocked driver and monitor around the block.
// Checks each response against a tolerance-based vertex welding predictor.
// Depends on tvdt_pkg, tvdt_req_if, tvdt_rsp_if and the block's RTL.
module tb_tolerant_vertex_dedup_table;
  import tvdt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNDEF      = 2'd3;
  localparam field_t           COORD_MAX      = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam field_t           COORD_MIN      = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam logic [TOL_W-1:0] TOL_MAX        = {TOL_W{1'b1}};
  localparam int               WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    field_t            x;
    field_t            y;
    field_t            z;
    logic [RIDX_W-1:0] ridx;
  } vertex_req_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [TOL_W-1:0] cfg_wdata_i;

  tvdt_req_if req_if ();
  tvdt_rsp_if rsp_if ();

  tolerant_vertex_dedup_table u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Requests waiting for the driver, and results waiting for the block
  vertex_req_t  vertex_req_q[$];
  tvdt_result_t weld_result_q[$];

  // Welding table as the block should hold it
  tvdt_point_t      weld_pt [TABLE_DEPTH];
  int               weld_count;
  logic [TOL_W-1:0] weld_tol;

  // Stimulus bookkeeping: recent map points and a rough entry count
  tvdt_point_t recent_pts[$];
  int          approx_entries;

  int          fail_count = 0;
  int          send_gap   = 0;
  int          send_burst = 1;
  int          stall_cycles = 0;
  logic [6:0]  ready_phase;
  logic [31:0] ready_mask = '1;
  vertex_req_t drv_item;
  vertex_req_t mon_item;
  tvdt_result_t mon_exp;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Per-axis test: |a - b| < tolerance, exact in 64 bits
  function automatic bit axis_within(field_t a, field_t b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return d < longint'(weld_tol);
  endfunction

  // Apply one request to the table and return the response it must produce
  function automatic tvdt_result_t weld_vertex(vertex_req_t rq);
    tvdt_result_t res;
    int hit_idx;
    res = '0;
    hit_idx = -1;
    case (rq.cmd)
      CMD_MAP: begin
        // Lowest matching index wins
        for (int i = 0; i < weld_count; i++) begin
          if (hit_idx < 0 && axis_within(rq.x, weld_pt[i].x) &&
              axis_within(rq.y, weld_pt[i].y) && axis_within(rq.z, weld_pt[i].z))
            hit_idx = i;
        end
        if (hit_idx >= 0) begin
          res.vertex_index = VIDX_W'(hit_idx);
          res.matched      = 1'b1;
          res.x            = weld_pt[hit_idx].x;
          res.y            = weld_pt[hit_idx].y;
          res.z            = weld_pt[hit_idx].z;
        end else if (weld_count >= TABLE_DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          weld_pt[weld_count] = {coord_t'(rq.x), coord_t'(rq.y), coord_t'(rq.z)};
          res.vertex_index    = VIDX_W'(weld_count);
          weld_count++;
        end
      end
      CMD_CLEAR: weld_count = 0;
      CMD_READ: begin
        res.vertex_index = rq.ridx;
        if (int'(rq.ridx) < weld_count) begin
          res.x = weld_pt[rq.ridx].x;
          res.y = weld_pt[rq.ridx].y;
          res.z = weld_pt[rq.ridx].z;
        end else begin
          res.status = STATUS_UNUSED;
        end
      end
      default: ;
    endcase
    res.entry_count = CNT_OUT_W'(weld_count);
    return res;
  endfunction

  task automatic compare_field(string tag, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, tag, exp_v, act_v);
      fail_count++;
    end
  endtask

  function automatic field_t rand_coord();
    field_t c;
    case ($urandom_range(0, 2))
      0:       c = field_t'($urandom);
      1:       c = field_t'($urandom_range(0, 32'h000F_FFFF)) - field_t'(32'h0008_0000);
      default: c = field_t'($urandom_range(0, 2047)) - field_t'(1024);
    endcase
    return c;
  endfunction

  // Coordinate near c: on the tolerance edge, just inside, or within twice it
  function automatic field_t near_coord(field_t c);
    longint t;
    longint off;
    longint raw;
    t   = longint'(weld_tol);
    raw = $urandom;
    case ($urandom_range(0, 6))
      0:       off = 0;
      1:       off = t - 1;
      2:       off = t;
      3:       off = 1 - t;
      4:       off = -t;
      default: off = raw % (4 * t + 1) - 2 * t;
    endcase
    return field_t'(longint'(c) + off);
  endfunction

  function automatic logic [RIDX_W-1:0] read_pick();
    if (approx_entries > 0 && $urandom_range(0, 3) != 0)
      return RIDX_W'($urandom_range(0, approx_entries - 1));
    return RIDX_W'($urandom);
  endfunction

  task automatic queue_req(logic [CMD_W-1:0] cmd, field_t x, field_t y, field_t z,
                           logic [RIDX_W-1:0] ridx);
    vertex_req_t item;
    item.cmd  = cmd;
    item.x    = x;
    item.y    = y;
    item.z    = z;
    item.ridx = ridx;
    vertex_req_q.push_back(item);
    if (cmd == CMD_MAP) begin
      recent_pts.push_back({x, y, z});
      if (recent_pts.size() > 64) void'(recent_pts.pop_front());
      if (approx_entries < TABLE_DEPTH) approx_entries++;
    end else if (cmd == CMD_CLEAR) begin
      approx_entries = 0;
    end
  endtask

  // Sample at the falling edge so driver and monitor updates have settled
  task automatic wait_drained();
    do @(negedge clk_i);
    while (vertex_req_q.size() != 0 || req_if.valid || weld_result_q.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_tolerance(logic [TOL_W-1:0] tol);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= tol;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    weld_tol = tol;
  endtask

  // Mostly maps around recent points, with reads, clears and noise mixed in
  task automatic run_random_phase(int n_items);
    tvdt_point_t c;
    int pick;
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55 && recent_pts.size() > 0) begin
        c = recent_pts[$urandom_range(0, recent_pts.size() - 1)];
        queue_req(CMD_MAP, near_coord(c.x), near_coord(c.y), near_coord(c.z),
                  RIDX_W'($urandom));
      end else if (pick < 75) begin
        queue_req(CMD_MAP, rand_coord(), rand_coord(), rand_coord(), RIDX_W'($urandom));
      end else if (pick < 90) begin
        queue_req(CMD_READ, rand_coord(), rand_coord(), rand_coord(), read_pick());
      end else if (pick < 94) begin
        queue_req(CMD_CLEAR, rand_coord(), rand_coord(), rand_coord(), RIDX_W'($urandom));
      end else if (pick < 97) begin
        queue_req(CMD_UNDEF, rand_coord(), rand_coord(), rand_coord(), RIDX_W'($urandom));
      end else begin
        queue_req(CMD_MAP, field_t'($urandom), field_t'($urandom), field_t'($urandom),
                  RIDX_W'($urandom));
      end
    end
  endtask

  // Request driver: bursts of random length separated by random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      if (send_gap > 0) begin
        req_if.valid <= 1'b0;
        send_gap     <= send_gap - 1;
      end else if (vertex_req_q.size() > 0) begin
        drv_item = vertex_req_q.pop_front();
        req_if.valid      <= 1'b1;
        req_if.cmd        <= drv_item.cmd;
        req_if.vertex_x   <= drv_item.x;
        req_if.vertex_y   <= drv_item.y;
        req_if.vertex_z   <= drv_item.z;
        req_if.read_index <= drv_item.ridx;
        if (send_burst <= 1) begin
          send_burst <= $urandom_range(1, 8);
          send_gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          send_burst <= send_burst - 1;
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response ready: a 32-bit mask replayed over a 7-bit phase counter, redrawn when it wraps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      ready_phase  <= '0;
    end else begin
      if (ready_phase == 7'd0) begin
        case ($urandom_range(0, 3))
          0:       ready_mask = '1;
          1:       ready_mask = $urandom & $urandom;
          default: ready_mask = $urandom;
        endcase
      end
      rsp_if.ready <= ready_mask[ready_phase[4:0]];
      ready_phase  <= ready_phase + 7'd1;
    end
  end

  // Monitor: check each response, then predict each accepted request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (weld_result_q.size() == 0) begin
          $display("%0t: response with no request pending, index %0h count %0h", $time,
                   rsp_if.vertex_index, rsp_if.entry_count);
          fail_count++;
        end else begin
          mon_exp = weld_result_q.pop_front();
          compare_field("vertex_index", mon_exp.vertex_index, rsp_if.vertex_index);
          compare_field("matched", mon_exp.matched, rsp_if.matched);
          compare_field("status", mon_exp.status, rsp_if.status);
          compare_field("stored_x", mon_exp.x, rsp_if.stored_x);
          compare_field("stored_y", mon_exp.y, rsp_if.stored_y);
          compare_field("stored_z", mon_exp.z, rsp_if.stored_z);
          compare_field("entry_count", mon_exp.entry_count, rsp_if.entry_count);
        end
      end
      if (req_if.valid && req_if.ready) begin
        mon_item.cmd  = req_if.cmd;
        mon_item.x    = req_if.vertex_x;
        mon_item.y    = req_if.vertex_y;
        mon_item.z    = req_if.vertex_z;
        mon_item.ridx = req_if.read_index;
        weld_result_q.push_back(weld_vertex(mon_item));
      end
    end
  end

  // Watchdog: end the run when no handshake happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tolerant_vertex_dedup_table verification failed");
      $finish;
    end
  end

  initial begin
    tvdt_point_t c;
    logic [TOL_W-1:0] tol;
    // Known values on every input before reset
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    req_if.valid      = 1'b0;
    req_if.cmd        = CMD_MAP;
    req_if.vertex_x   = '0;
    req_if.vertex_y   = '0;
    req_if.vertex_z   = '0;
    req_if.read_index = '0;
    rsp_if.ready      = 1'b0;
    weld_tol          = TOL_RESET;
    weld_count        = 0;
    approx_entries    = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset tolerance: edges of the tolerance, extremes, lowest index wins
    queue_req(CMD_MAP, 0, 0, 0, 0);
    queue_req(CMD_MAP, 654, -654, 0, 0);
    queue_req(CMD_MAP, 655, 0, 0, 0);
    queue_req(CMD_MAP, -655, 0, 0, 0);
    queue_req(CMD_MAP, COORD_MAX, COORD_MAX, COORD_MAX, 0);
    queue_req(CMD_MAP, COORD_MIN, COORD_MIN, COORD_MIN, 0);
    queue_req(CMD_MAP, COORD_MAX - 654, COORD_MAX, COORD_MAX - 1, 0);
    queue_req(CMD_MAP, COORD_MIN + 654, COORD_MIN, COORD_MIN, 0);
    queue_req(CMD_MAP, 0, 0, 655, 0);
    queue_req(CMD_MAP, 1, 1, 1, 0);
    queue_req(CMD_MAP, 327, 0, 327, 0);
    queue_req(CMD_READ, 0, 0, 0, 0);
    queue_req(CMD_READ, 0, 0, 0, 5);
    queue_req(CMD_READ, 0, 0, 0, 6);
    queue_req(CMD_READ, COORD_MAX, COORD_MAX, COORD_MAX, {RIDX_W{1'b1}});
    queue_req(CMD_UNDEF, COORD_MIN, COORD_MAX, -1, 8'h55);
    queue_req(CMD_MAP, 32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA, 8'hAA);
    queue_req(CMD_MAP, 32'sh55555555, 32'shAAAAAAAA, 32'sh55555555, 8'h55);
    queue_req(CMD_CLEAR, -1, -1, -1, {RIDX_W{1'b1}});
    queue_req(CMD_READ, 0, 0, 0, 0);
    queue_req(CMD_MAP, 654, 654, 654, 0);
    queue_req(CMD_UNDEF, 0, 0, 0, 0);

    // Zero tolerance: identical points still append
    set_tolerance('0);
    queue_req(CMD_MAP, 100, 200, 300, 0);
    queue_req(CMD_MAP, 100, 200, 300, 0);
    queue_req(CMD_MAP, 654, 654, 654, 0);
    queue_req(CMD_READ, 0, 0, 0, 2);

    // Largest tolerance: the 33-bit difference must not wrap
    set_tolerance(TOL_MAX);
    queue_req(CMD_CLEAR, 0, 0, 0, 0);
    queue_req(CMD_MAP, COORD_MIN, COORD_MIN, COORD_MIN, 0);
    queue_req(CMD_MAP, COORD_MAX, COORD_MAX, COORD_MAX, 0);
    queue_req(CMD_MAP, 0, 0, 0, 0);
    queue_req(CMD_MAP, 1, 1, 1, 0);
    queue_req(CMD_MAP, -1, -1, -1, 0);

    // Fill the table with zero tolerance, then overflow it
    set_tolerance('0);
    queue_req(CMD_CLEAR, 0, 0, 0, 0);
    for (int k = 0; k < TABLE_DEPTH + 2; k++)
      queue_req(CMD_MAP, rand_coord(), rand_coord(), rand_coord(), RIDX_W'($urandom));

    // Full table, exact tolerance: repeats match, new points report full
    set_tolerance(1);
    for (int k = 0; k < 20; k++) begin
      c = recent_pts[$urandom_range(0, recent_pts.size() - 1)];
      case ($urandom_range(0, 2))
        0:       queue_req(CMD_MAP, c.x, c.y, c.z, 0);
        1:       queue_req(CMD_MAP, rand_coord(), rand_coord(), rand_coord(), 0);
        default: queue_req(CMD_READ, 0, 0, 0, read_pick());
      endcase
    end

    // Random phases over a spread of tolerances
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       tol = 1;
        1:       tol = TOL_W'($urandom_range(1, 4096));
        2:       tol = TOL_W'($urandom >> $urandom_range(1, 31));
        3:       tol = TOL_W'($urandom_range(0, 32'h7FFF_FFFF));
        4:       tol = TOL_RESET;
        default: tol = TOL_W'($urandom_range(0, 65536));
      endcase
      set_tolerance(tol);
      if ($urandom_range(0, 1) == 0)
        queue_req(CMD_CLEAR, rand_coord(), rand_coord(), rand_coord(), RIDX_W'($urandom));
      run_random_phase(50);
    end

    // Drain, let the block settle, then report
    wait_drained();
    repeat (300) @(posedge clk_i);
    if (weld_result_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, weld_result_q.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("tolerant_vertex_dedup_table verification clean");
    else
      $display("tolerant_vertex_dedup_table verification failed");
    $finish;
  end

endmodule
